FILE: src/mpr_pkg.sv
// Shared types, constants and helper functions for the mouse packet reader.
package mpr_pkg;

  typedef enum logic [1:0] {
    CMD_MOVE   = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_BUTTON = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    SLOT_IDLE   = 3'd0,
    SLOT_X      = 3'd1,
    SLOT_Y      = 3'd2,
    SLOT_BTN    = 3'd3,
    SLOT_SCROLL = 3'd4
  } slot_t;

  localparam int unsigned NUM_BUTTONS = 3;

  localparam logic [1:0] TAG_X      = 2'b01;
  localparam logic [1:0] TAG_Y      = 2'b10;
  localparam logic [1:0] TAG_BTN    = 2'b11;
  localparam logic [2:0] TAG_SCROLL = 3'b111;
  localparam logic [7:0] END_BYTE   = 8'h00;

  localparam logic signed [15:0] ACC_MAX = 16'sh7FFF;
  localparam logic signed [15:0] ACC_MIN = 16'sh8000;

  localparam logic signed [16:0] MOT_HI    = 17'sd31;
  localparam logic signed [16:0] MOT_LO    = -17'sd32;
  localparam logic signed [16:0] SCROLL_HI = 17'sd15;
  localparam logic signed [16:0] SCROLL_LO = -17'sd16;

  // Host event as seen by the accumulator stage.
  typedef struct packed {
    logic              fire;
    cmd_t              cmd;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dscroll;
    logic [1:0]        button_index;
    logic              button_pressed;
  } mpr_event_t;

  // Accumulated motion, or its snapshot.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] scroll;
    logic [NUM_BUTTONS-1:0] buttons;
    logic               dirty;
  } mpr_motion_t;

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      return s[16] ? ACC_MIN : ACC_MAX;
    end
    return s[15:0];
  endfunction

  function automatic logic signed [16:0] neg17(input logic signed [15:0] v);
    return 17'sd0 - {v[15], v};
  endfunction

  function automatic logic [5:0] clamp6(input logic signed [16:0] v);
    logic [5:0] r;
    if (v > MOT_HI) begin
      r = MOT_HI[5:0];
    end else if (v < MOT_LO) begin
      r = MOT_LO[5:0];
    end else begin
      r = v[5:0];
    end
    return r;
  endfunction

  function automatic logic [4:0] clamp5(input logic signed [16:0] v);
    logic [4:0] r;
    if (v > SCROLL_HI) begin
      r = SCROLL_HI[4:0];
    end else if (v < SCROLL_LO) begin
      r = SCROLL_LO[4:0];
    end else begin
      r = v[4:0];
    end
    return r;
  endfunction

endpackage

FILE: src/mpr_if.sv
// Valid/ready channel interfaces for host events and read bytes.
interface mpr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [15:0] move_x;
  logic signed [15:0] move_y;
  logic signed [15:0] scroll_delta;
  logic [1:0]        button_index;
  logic              button_pressed;

  modport source (output valid, cmd, move_x, move_y, scroll_delta, button_index,
                  button_pressed, input ready);
  modport sink (input valid, cmd, move_x, move_y, scroll_delta, button_index,
                button_pressed, output ready);
endinterface

interface mpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;

  modport source (output valid, read_byte, input ready);
  modport sink (input valid, read_byte, output ready);
endinterface

FILE: src/ps2_mouse_packet_reader.sv
// Top level of the mouse packet reader: input register, state logic, result register.
//
// Usage:
//   item   : host beats. cmd selects move (adds move_x/move_y), scroll (adds
//            scroll_delta), button event (button_index/button_pressed) or read.
//   result : one read_byte beat for every read; other commands give none.
// A read at the start of a burst snapshots and clears the motion sums; later
// reads walk X, Y, buttons and scroll, skipping empty ones. 0x00 ends a burst.
// Path: an accepted beat is held in the input register; a read's byte then goes
// into the result register once that register is free.
// Throughput: one beat per cycle unless a read stalls, set by the single pass
// from input register through accumulator and slot logic into result register.
// The result register lets a new beat enter while a byte waits to be taken.
// Reset clears the accumulators, buttons, snapshot, slot and both valid flags.
// When result is stalled, events still flow; a read waits in the input register
// and item.ready drops only while that read and a waiting byte are both held.
module ps2_mouse_packet_reader (
  input  logic         clk,
  input  logic         rst,
  mpr_in_if.sink       item,
  mpr_out_if.source    result
);
  import mpr_pkg::*;

  logic              in_valid;
  cmd_t              in_cmd;
  logic signed [15:0] in_x;
  logic signed [15:0] in_y;
  logic signed [15:0] in_scroll;
  logic [1:0]        in_bidx;
  logic              in_pressed;

  logic              out_valid;
  logic [7:0]        out_byte;

  logic              out_free;
  logic              process;
  logic              is_read;
  logic              read_fire;
  logic              clear;
  logic [7:0]        pick_byte;
  mpr_event_t        ev;
  mpr_motion_t       acc;

  assign is_read   = (in_cmd == CMD_READ);
  assign out_free  = !out_valid || result.ready;
  assign process   = in_valid && (!is_read || out_free);
  assign read_fire = process && is_read;
  assign item.ready = !in_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_cmd     <= cmd_t'(item.cmd);
      in_x       <= item.move_x;
      in_y       <= item.move_y;
      in_scroll  <= item.scroll_delta;
      in_bidx    <= item.button_index;
      in_pressed <= item.button_pressed;
    end
  end

  always_comb begin
    ev.fire           = process && !is_read;
    ev.cmd            = in_cmd;
    ev.dx             = in_x;
    ev.dy             = in_y;
    ev.dscroll        = in_scroll;
    ev.button_index   = in_bidx;
    ev.button_pressed = in_pressed;
  end

  mpr_accum u_accum (
    .clk   (clk),
    .rst   (rst),
    .ev    (ev),
    .clear (clear),
    .acc   (acc)
  );

  mpr_readout u_readout (
    .clk      (clk),
    .rst      (rst),
    .fire     (read_fire),
    .acc      (acc),
    .clear    (clear),
    .byte_out (pick_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= read_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (read_fire) begin
      out_byte <= pick_byte;
    end
  end

  assign result.valid     = out_valid;
  assign result.read_byte = out_byte;

endmodule

FILE: src/mpr_accum.sv
// Saturating motion accumulators and button level register.
module mpr_accum (
  input  logic                clk,
  input  logic                rst,
  input  mpr_pkg::mpr_event_t ev,
  input  logic                clear,
  output mpr_pkg::mpr_motion_t acc
);
  import mpr_pkg::*;

  mpr_motion_t acc_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_q <= '0;
    end else if (clear) begin
      // snapshot taken: motion and change mark restart, levels stay
      acc_q.x      <= '0;
      acc_q.y      <= '0;
      acc_q.scroll <= '0;
      acc_q.dirty  <= 1'b0;
    end else if (ev.fire) begin
      case (ev.cmd)
        CMD_MOVE: begin
          acc_q.x <= sat_add(acc_q.x, ev.dx);
          acc_q.y <= sat_add(acc_q.y, ev.dy);
        end
        CMD_SCROLL: begin
          acc_q.scroll <= sat_add(acc_q.scroll, ev.dscroll);
        end
        CMD_BUTTON: begin
          if (ev.button_index < 2'(NUM_BUTTONS)) begin
            acc_q.buttons[ev.button_index] <= ev.button_pressed;
            acc_q.dirty <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign acc = acc_q;

endmodule

FILE: src/mpr_readout.sv
// Burst snapshot, slot pointer and packet byte selection.
module mpr_readout (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  mpr_pkg::mpr_motion_t acc,
  output logic                 clear,
  output logic [7:0]           byte_out
);
  import mpr_pkg::*;

  mpr_motion_t snap;
  mpr_motion_t src;
  slot_t       slot;
  slot_t       slot_next;
  slot_t       start;
  logic        hit_x;
  logic        hit_y;
  logic        hit_b;

  // At burst start the live accumulators are read directly.
  assign src   = (slot == SLOT_IDLE) ? acc : snap;
  assign start = (slot == SLOT_IDLE) ? SLOT_X : slot;
  assign clear = fire && (slot == SLOT_IDLE);

  assign hit_x = (src.x != '0) && (start <= SLOT_X);
  assign hit_y = (src.y != '0) && (start <= SLOT_Y);
  assign hit_b = src.dirty && (start <= SLOT_BTN);

  always_comb begin
    byte_out  = END_BYTE;
    slot_next = SLOT_IDLE;
    if (start > SLOT_SCROLL) begin
      byte_out  = END_BYTE;
      slot_next = SLOT_IDLE;
    end else if (hit_x) begin
      byte_out  = {TAG_X, clamp6({src.x[15], src.x})};
      slot_next = SLOT_Y;
    end else if (hit_y) begin
      byte_out  = {TAG_Y, clamp6(neg17(src.y))};
      slot_next = SLOT_BTN;
    end else if (hit_b) begin
      byte_out  = {TAG_BTN, 3'b000, src.buttons};
      slot_next = SLOT_SCROLL;
    end else begin
      byte_out  = (src.scroll != '0) ? {TAG_SCROLL, clamp5(neg17(src.scroll))} : END_BYTE;
      slot_next = SLOT_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SLOT_IDLE;
      snap <= '0;
    end else if (fire) begin
      slot <= slot_next;
      if (slot == SLOT_IDLE) begin
        snap <= acc;
      end
    end
  end

endmodule

FILE: src/mpr_checker.sv
// Port-level checks for the mouse packet reader, bound to the top level.
module mpr_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] read_byte
);
  import mpr_pkg::*;

  // A stalled byte holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(read_byte))
    else $error("result byte changed while stalled");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // Input backpressure only comes from a held read behind a stalled byte.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("item stalled while result side is free");

  // Byte format: tag 00 only for the end marker, button bytes keep 5:3 clear.
  a_format: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (read_byte[7:6] != 2'b00 || read_byte == END_BYTE) &&
                     (read_byte[7:5] != 3'b110 || read_byte[4:3] == 2'b00))
    else $error("malformed packet byte");

endmodule

bind ps2_mouse_packet_reader mpr_checker u_mpr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .read_byte    (result.read_byte)
);
